FILE: design/hbs_pkg.sv
`default_nettype none
package hbs_pkg;

	localparam int MAX_SIDE    = 256;
	localparam int SIDE_W      = $clog2(MAX_SIDE + 1);
	localparam int IDX_W       = $clog2(MAX_SIDE);
	localparam int STORE_DEPTH = 65536;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int SAMPLE_W    = 42;
	localparam int WEIGHT_W    = 17;

	localparam logic [2:0] REG_ORIGIN_X     = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Z     = 3'd1;
	localparam logic [2:0] REG_UV_SCALE     = 3'd2;
	localparam logic [2:0] REG_HEIGHT_SCALE = 3'd3;
	localparam logic [2:0] REG_MAP_WIDTH    = 3'd4;
	localparam logic [2:0] REG_MAP_HEIGHT   = 3'd5;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// half bits to signed q.24, inf as +-65536, nan as 0
	function automatic sample_t half_to_q24(input logic [15:0] h);
		logic [4:0]  e;
		logic [9:0]  m;
		logic [40:0] mag;
		e = h[14:10];
		m = h[9:0];
		if (e == 5'd31) begin
			mag = (m != 10'd0) ? 41'd0 : (41'd1 << 40);
		end else if (e == 5'd0) begin
			mag = 41'(m);
		end else begin
			mag = 41'({1'b1, m}) << (e - 5'd1);
		end
		half_to_q24 = h[15] ? -sample_t'(mag) : sample_t'(mag);
	endfunction

	// a + (b - a) * w in q.40, floored back to q.24
	function automatic sample_t lerp_q24(input sample_t a, input sample_t b,
		input logic [WEIGHT_W-1:0] w);
		logic signed [SAMPLE_W:0]   dif;
		logic signed [WEIGHT_W:0]   ws;
		logic signed [60:0]         prod;
		logic signed [60:0]         sum;
		dif  = (SAMPLE_W+1)'(b) - (SAMPLE_W+1)'(a);
		ws   = {1'b0, w};
		prod = dif * ws;
		sum  = (61'(a) <<< 16) + prod;
		lerp_q24 = SAMPLE_W'(sum >>> 16);
	endfunction

endpackage
`default_nettype wire

FILE: design/heightmap_bilinear_sampler.sv
`default_nettype none
// channel   dir  tdata (lowest bit up)                              tuser
// s_axis    in   texel_address, texel_value, query_x, query_z       opcode
// m_axis    out  height                                             -
// cfg       in   cfg_wr_en, cfg_addr, cfg_wdata (register write)    -
//
// one beat enters per cycle unless m_axis stalls; each query gives one height, writes give none
// the height map sits in four copies, one per neighbour texel, read at stage 6
// writes pass along the pipeline and land in the copies at that same stage
// reset clears valid bits and registers; the map contents stay undefined
// a stall at m_axis freezes every stage together, nothing lost or repeated
module heightmap_bilinear_sampler (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [95:0]  s_axis_tdata,  // texel_address, texel_value, query_x, query_z
	input  wire logic [0:0]   s_axis_tuser,  // opcode
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [31:0]       m_axis_tdata,  // height
	input  wire logic         cfg_wr_en,
	input  wire logic [2:0]   cfg_addr,
	input  wire logic [31:0]  cfg_wdata
);

	localparam int IW = hbs_pkg::IDX_W;
	localparam int SW = hbs_pkg::SIDE_W;
	localparam int AW = hbs_pkg::ADDR_W;
	localparam int WW = hbs_pkg::WEIGHT_W;
	localparam int SAMPLE_MSB = hbs_pkg::SAMPLE_W - 1;

	logic signed [31:0] origin_x_q, origin_z_q;
	logic [31:0]        uv_scale_q, height_scale_q;
	logic [8:0]         map_width_q, map_height_q;
	logic [SW-1:0]      eff_w, eff_h;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q     <= '0;
			origin_z_q     <= '0;
			uv_scale_q     <= '0;
			height_scale_q <= 32'd65536;
			map_width_q    <= 9'd256;
			map_height_q   <= 9'd256;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				hbs_pkg::REG_ORIGIN_X:     origin_x_q     <= cfg_wdata;
				hbs_pkg::REG_ORIGIN_Z:     origin_z_q     <= cfg_wdata;
				hbs_pkg::REG_UV_SCALE:     uv_scale_q     <= cfg_wdata;
				hbs_pkg::REG_HEIGHT_SCALE: height_scale_q <= cfg_wdata;
				hbs_pkg::REG_MAP_WIDTH:    map_width_q    <= cfg_wdata[8:0];
				hbs_pkg::REG_MAP_HEIGHT:   map_height_q   <= cfg_wdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (map_width_q == 9'd0)
			eff_w = SW'(1);
		else if (32'(map_width_q) > 32'(hbs_pkg::MAX_SIDE))
			eff_w = SW'(hbs_pkg::MAX_SIDE);
		else
			eff_w = SW'(map_width_q);
		if (map_height_q == 9'd0)
			eff_h = SW'(1);
		else if (32'(map_height_q) > 32'(hbs_pkg::MAX_SIDE))
			eff_h = SW'(hbs_pkg::MAX_SIDE);
		else
			eff_h = SW'(map_height_q);
	end

	// global advance
	logic adv;
	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;
	logic op_s1, op_s2, op_s3, op_s4, op_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6} <= '0;
			{v_s7, v_s8, v_s9, v_s10, v_s11}     <= '0;
		end else if (adv) begin
			v_s1  <= s_axis_tvalid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5 && (op_s5 == hbs_pkg::OP_QUERY);
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
		end
	end

	// stage 1: offset from origin
	logic signed [32:0] dx, dz;
	logic [AW-1:0] wa_s1, wa_s2, wa_s3, wa_s4, wa_s5;
	logic [15:0]   wd_s1, wd_s2, wd_s3, wd_s4, wd_s5;
	logic [31:0]   magx_s1, magz_s1;
	logic          negx_s1, negz_s1;

	assign dx = 33'(signed'(s_axis_tdata[63:32])) - 33'(origin_x_q);
	assign dz = 33'(signed'(s_axis_tdata[95:64])) - 33'(origin_z_q);

	// stage 2: world-to-uv product
	logic [63:0] px_s2, pz_s2;
	logic        negx_s2, negz_s2;

	// stage 3: add half, clamp
	logic [63:0] tx_m, tz_m;
	logic [32:0] ux, uz, u_s3, v_s3u;

	always_comb begin
		tx_m = negx_s2 ? ((px_s2 + 64'hFFFF) >> 16) : (px_s2 >> 16);
		tz_m = negz_s2 ? ((pz_s2 + 64'hFFFF) >> 16) : (pz_s2 >> 16);
		if (negx_s2)
			ux = (tx_m >= 64'h8000_0000) ? 33'd0 : 33'h0_8000_0000 - 33'(tx_m);
		else
			ux = (tx_m >= 64'h8000_0000) ? 33'h1_0000_0000 : 33'h0_8000_0000 + 33'(tx_m);
		if (negz_s2)
			uz = (tz_m >= 64'h8000_0000) ? 33'd0 : 33'h0_8000_0000 - 33'(tz_m);
		else
			uz = (tz_m >= 64'h8000_0000) ? 33'h1_0000_0000 : 33'h0_8000_0000 + 33'(tz_m);
	end

	// stage 4: texel index and weight
	logic [41:0]   fx, fz;
	logic [IW-1:0] u0, u1, r0, r1, lastx, lasty;
	logic [WW-1:0] wu, wv;
	logic [IW-1:0] u0_s4, u1_s4, r0_s4, r1_s4;
	logic [WW-1:0] wu_s4, wv_s4, wu_s5, wv_s5;

	always_comb begin
		fx    = 42'(u_s3) * 42'(eff_w);
		fz    = 42'(v_s3u) * 42'(eff_h);
		lastx = IW'(eff_w - SW'(1));
		lasty = IW'(eff_h - SW'(1));
		if (fx[41:32] > 10'(lastx)) begin
			u0 = lastx;
			wu = WW'(65536);
		end else begin
			u0 = IW'(fx[41:32]);
			wu = WW'(fx[31:16]);
		end
		if (fz[41:32] > 10'(lasty)) begin
			r0 = lasty;
			wv = WW'(65536);
		end else begin
			r0 = IW'(fz[41:32]);
			wv = WW'(fz[31:16]);
		end
		u1 = (u0 >= lastx) ? lastx : u0 + IW'(1);
		r1 = (r0 >= lasty) ? lasty : r0 + IW'(1);
	end

	// stage 5: addresses
	logic [16:0]   row0, row1;
	logic [AW-1:0] a00_s5, a01_s5, a10_s5, a11_s5;

	assign row0 = 17'(r0_s4) * 17'(eff_w);
	assign row1 = 17'(r1_s4) * 17'(eff_w);

	// stage 6: map read
	logic [15:0] bank0_q [0:hbs_pkg::STORE_DEPTH-1];
	logic [15:0] bank1_q [0:hbs_pkg::STORE_DEPTH-1];
	logic [15:0] bank2_q [0:hbs_pkg::STORE_DEPTH-1];
	logic [15:0] bank3_q [0:hbs_pkg::STORE_DEPTH-1];
	logic [15:0] h00_s6, h01_s6, h10_s6, h11_s6;
	logic        map_wr;

	assign map_wr = adv && v_s5 && (op_s5 == hbs_pkg::OP_WRITE);

	always_ff @(posedge clk) begin
		if (map_wr) begin
			bank0_q[wa_s5] <= wd_s5;
			bank1_q[wa_s5] <= wd_s5;
			bank2_q[wa_s5] <= wd_s5;
			bank3_q[wa_s5] <= wd_s5;
		end
		if (adv) begin
			h00_s6 <= bank0_q[a00_s5];
			h01_s6 <= bank1_q[a01_s5];
			h10_s6 <= bank2_q[a10_s5];
			h11_s6 <= bank3_q[a11_s5];
		end
	end

	logic [WW-1:0] wu_s6, wv_s6, wu_s7, wv_s7, wv_s8;
	hbs_pkg::sample_t s00_s7, s01_s7, s10_s7, s11_s7;
	hbs_pkg::sample_t top_s8, bot_s8, smp_s9;
	logic [40:0] smag;
	logic        neg_s10;
	logic [55:0] pl_s10;
	logic [48:0] ph_s10;
	logic [32:0] lowp;
	logic [49:0] prod;
	logic [31:0] height_s11;

	assign smag = smp_s9[SAMPLE_MSB] ? 41'(-smp_s9) : 41'(smp_s9);

	always_comb begin
		lowp = neg_s10 ? 33'((57'(pl_s10) + 57'hFF_FFFF) >> 24) : 33'(pl_s10 >> 24);
		prod = 50'(ph_s10) + 50'(lowp);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wa_s1   <= s_axis_tdata[15:0];
			wd_s1   <= s_axis_tdata[31:16];
			op_s1   <= s_axis_tuser[0];
			negx_s1 <= dx[32];
			negz_s1 <= dz[32];
			magx_s1 <= dx[32] ? 32'(-dx) : 32'(dx);
			magz_s1 <= dz[32] ? 32'(-dz) : 32'(dz);

			wa_s2   <= wa_s1;
			wd_s2   <= wd_s1;
			op_s2   <= op_s1;
			negx_s2 <= negx_s1;
			negz_s2 <= negz_s1;
			px_s2   <= 64'(magx_s1) * 64'(uv_scale_q);
			pz_s2   <= 64'(magz_s1) * 64'(uv_scale_q);

			wa_s3 <= wa_s2;
			wd_s3 <= wd_s2;
			op_s3 <= op_s2;
			u_s3  <= ux;
			v_s3u <= uz;

			wa_s4 <= wa_s3;
			wd_s4 <= wd_s3;
			op_s4 <= op_s3;
			u0_s4 <= u0;
			u1_s4 <= u1;
			r0_s4 <= r0;
			r1_s4 <= r1;
			wu_s4 <= wu;
			wv_s4 <= wv;

			wa_s5  <= wa_s4;
			wd_s5  <= wd_s4;
			op_s5  <= op_s4;
			wu_s5  <= wu_s4;
			wv_s5  <= wv_s4;
			a00_s5 <= AW'(row0 + 17'(u0_s4));
			a01_s5 <= AW'(row0 + 17'(u1_s4));
			a10_s5 <= AW'(row1 + 17'(u0_s4));
			a11_s5 <= AW'(row1 + 17'(u1_s4));

			wu_s6 <= wu_s5;
			wv_s6 <= wv_s5;

			wu_s7  <= wu_s6;
			wv_s7  <= wv_s6;
			s00_s7 <= hbs_pkg::half_to_q24(h00_s6);
			s01_s7 <= hbs_pkg::half_to_q24(h01_s6);
			s10_s7 <= hbs_pkg::half_to_q24(h10_s6);
			s11_s7 <= hbs_pkg::half_to_q24(h11_s6);

			wv_s8  <= wv_s7;
			top_s8 <= hbs_pkg::lerp_q24(s00_s7, s01_s7, wu_s7);
			bot_s8 <= hbs_pkg::lerp_q24(s10_s7, s11_s7, wu_s7);

			smp_s9 <= hbs_pkg::lerp_q24(top_s8, bot_s8, wv_s8);

			neg_s10 <= smp_s9[SAMPLE_MSB];
			ph_s10  <= 49'(smag[40:24]) * 49'(height_scale_q);
			pl_s10  <= 56'(smag[23:0]) * 56'(height_scale_q);

			if (neg_s10)
				height_s11 <= (prod > 50'h8000_0000) ? 32'h8000_0000 : 32'(-prod);
			else
				height_s11 <= (prod > 50'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(prod);
		end
	end

	assign m_axis_tvalid = v_s11;
	assign m_axis_tdata  = height_s11;

endmodule
`default_nettype wire

FILE: tb/heightmap_bilinear_sampler_tb.sv
`timescale 1ns / 100ps
module heightmap_bilinear_sampler_tb;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [95:0] s_axis_tdata;
	logic [0:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic        cfg_wr_en;
	logic [2:0]  cfg_addr;
	logic [31:0] cfg_wdata;

	heightmap_bilinear_sampler dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	// predictor copy of the registers and the map
	logic signed [31:0] org_x, org_z;
	logic [31:0]        uv_scale, h_scale;
	logic [8:0]         side_w, side_h;
	logic [15:0]        texels [65536];
	bit                 texel_set [65536];

	logic [31:0] heights_due [$];
	int          errors, results, n_queries, n_writes, idle_pct, stall_pct, quiet;
	logic        draining;

	typedef struct {
		logic        op;
		logic [15:0] addr;
		logic [15:0] val;
		logic [31:0] qx;
		logic [31:0] qz;
		bit          typed;
		logic [31:0] height;
	} stim_row_t;

	localparam logic [15:0] MID = 16'd32896;
	localparam logic WR = hbs_pkg::OP_WRITE;
	localparam logic QR = hbs_pkg::OP_QUERY;
	stim_row_t rows [20] = '{
		'{WR, 16'h0000, 16'h0000, 32'h0, 32'h0, 0, 32'h0},
		'{WR, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'h0, 0, 32'h0},
		'{WR, MID, 16'h3C00, 32'h0, 32'h0, 0, 32'h0},
		'{QR, 16'hFFFF, 16'hFFFF, 32'h7FFFFFFF, 32'h80000000, 1, 32'h00010000},
		'{WR, MID, 16'h7C00, 32'h0, 32'h0, 0, 32'h0},
		'{QR, 16'h0, 16'h0, 32'h80000000, 32'h7FFFFFFF, 1, 32'h7FFFFFFF},
		'{WR, MID, 16'hFC00, 32'h0, 32'h0, 0, 32'h0},
		'{QR, 16'h0, 16'h0, 32'h0, 32'h0, 1, 32'h80000000},
		'{WR, MID, 16'h7E00, 32'h0, 32'h0, 0, 32'h0},
		'{QR, 16'h0, 16'h0, 32'h0, 32'h0, 1, 32'h00000000},
		'{WR, MID, 16'h0001, 32'h0, 32'h0, 0, 32'h0},
		'{QR, 16'h0, 16'h0, 32'h0, 32'h0, 1, 32'h00000000},
		'{WR, MID, 16'h8001, 32'h0, 32'h0, 0, 32'h0},
		'{QR, 16'h0, 16'h0, 32'h0, 32'h0, 1, 32'hFFFFFFFF},
		'{WR, MID, 16'h7BFF, 32'h0, 32'h0, 0, 32'h0},
		'{QR, 16'h0, 16'h0, 32'h0, 32'h0, 1, 32'h7FFFFFFF},
		'{WR, MID, 16'hC000, 32'h0, 32'h0, 0, 32'h0},
		'{QR, 16'h0, 16'h0, 32'h0, 32'h0, 1, 32'hFFFE0000},
		'{WR, MID, 16'h3555, 32'h1234, 32'h0, 0, 32'h0},
		'{QR, 16'h0, 16'h0, 32'h0, 32'h0, 0, 32'h0}
	};

	function automatic int eff_side(input logic [8:0] s);
		if (s == 9'd0)
			return 1;
		if (s > hbs_pkg::MAX_SIDE)
			return hbs_pkg::MAX_SIDE;
		return int'(s);
	endfunction

	function automatic longint half_fixed(input logic [15:0] hb);
		longint mag;
		if (hb[14:10] == 5'd31) begin
			if (hb[9:0] != 10'd0)
				return 0;
			mag = longint'(1) << 40;
		end else if (hb[14:10] == 5'd0) begin
			mag = longint'(hb[9:0]);
		end else begin
			mag = longint'({1'b1, hb[9:0]}) << (hb[14:10] - 1);
		end
		return hb[15] ? -mag : mag;
	endfunction

	// texel indices and q.16 weight along one axis
	function automatic void axis_pos(input logic signed [31:0] q, input logic signed [31:0] org,
		input int size, output int i0, output int i1, output longint wt);
		longint      d, mag, t, uv;
		logic [63:0] p, f;
		d   = longint'(q) - longint'(org);
		mag = (d < 0) ? -d : d;
		p   = 64'(mag) * 64'(uv_scale);
		if (d < 0)
			t = -longint'((p + 64'hFFFF) >> 16);
		else
			t = longint'(p >> 16);
		uv = (longint'(1) << 31) + t;
		if (uv < 0)
			uv = 0;
		if (uv > (longint'(1) << 32))
			uv = longint'(1) << 32;
		f  = 64'(uv) * 64'(size);
		i0 = int'(f >> 32);
		if (i0 > size - 1)
			i0 = size - 1;
		i1 = (i0 + 1 > size - 1) ? size - 1 : i0 + 1;
		wt = longint'((f - (64'(i0) << 32)) >> 16);
	endfunction

	function automatic void corner_addrs(input logic [31:0] qx, input logic [31:0] qz,
		output int a [4], output longint wu, output longint wv);
		int w, h, u0, u1, v0, v1;
		w = eff_side(side_w);
		h = eff_side(side_h);
		axis_pos(qx, org_x, w, u0, u1, wu);
		axis_pos(qz, org_z, h, v0, v1, wv);
		a[0] = (v0 * w + u0) & 16'hFFFF;
		a[1] = (v0 * w + u1) & 16'hFFFF;
		a[2] = (v1 * w + u0) & 16'hFFFF;
		a[3] = (v1 * w + u1) & 16'hFFFF;
	endfunction

	function automatic longint blend(input longint a, input longint b, input longint wt);
		return (a * 65536 + (b - a) * wt) >>> 16;
	endfunction

	function automatic logic [31:0] sampled_height(input logic [31:0] qx, input logic [31:0] qz);
		int                  a [4];
		longint              wu, wv, top, bot, s;
		logic signed [127:0] sw, hw, pr, hi_lim, lo_lim;
		corner_addrs(qx, qz, a, wu, wv);
		top    = blend(half_fixed(texels[a[0]]), half_fixed(texels[a[1]]), wu);
		bot    = blend(half_fixed(texels[a[2]]), half_fixed(texels[a[3]]), wu);
		s      = blend(top, bot, wv);
		sw     = s;
		hw     = {96'd0, h_scale};
		pr     = (sw * hw) >>> 24;
		hi_lim = 128'sd2147483647;
		lo_lim = -128'sd2147483648;
		if (pr > hi_lim)
			pr = hi_lim;
		if (pr < lo_lim)
			pr = lo_lim;
		return pr[31:0];
	endfunction

	task automatic push_beat(input logic op, input logic [15:0] ad, input logic [15:0] val,
		input logic [31:0] qx, input logic [31:0] qz, input bit typed, input logic [31:0] ht);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {qz, qx, val, ad};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (op == hbs_pkg::OP_WRITE) begin
			texels[ad]    = val;
			texel_set[ad] = 1;
			n_writes++;
		end else begin
			heights_due.insert(heights_due.size(), typed ? ht : sampled_height(qx, qz));
			n_queries++;
		end
	endtask

	// fill any corner never written, then send the query
	task automatic run_query(input logic [31:0] qx, input logic [31:0] qz, input bit typed,
		input logic [31:0] ht);
		int     a [4];
		longint wu, wv;
		corner_addrs(qx, qz, a, wu, wv);
		for (int k = 0; k < 4; k++) begin
			if (!texel_set[a[k]])
				push_beat(hbs_pkg::OP_WRITE, 16'(a[k]), 16'($urandom), $urandom, $urandom,
					0, 0);
		end
		push_beat(hbs_pkg::OP_QUERY, 16'($urandom), 16'($urandom), qx, qz, typed, ht);
	endtask

	task automatic set_reg(input logic [2:0] idx, input logic [31:0] v);
		cfg_wr_en <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= v;
		case (idx)
			hbs_pkg::REG_ORIGIN_X:     org_x = v;
			hbs_pkg::REG_ORIGIN_Z:     org_z = v;
			hbs_pkg::REG_UV_SCALE:     uv_scale = v;
			hbs_pkg::REG_HEIGHT_SCALE: h_scale = v;
			hbs_pkg::REG_MAP_WIDTH:    side_w = v[8:0];
			hbs_pkg::REG_MAP_HEIGHT:   side_h = v[8:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic drain;
		s_axis_tvalid <= 1'b0;
		draining      <= 1'b1;
		while (heights_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		draining <= 1'b0;
	endtask

	function automatic logic [31:0] near_origin(input logic [31:0] org);
		int k;
		k = $urandom_range(31, 4);
		return org + (($urandom & ((32'd1 << k) - 1)) - (32'd1 << (k - 1)));
	endfunction

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// output side: check heights and stall at random
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results++;
			if (heights_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected height beat, expected none, actual %h",
					$realtime, m_axis_tdata);
			end else if (m_axis_tdata !== heights_due[0]) begin
				errors++;
				$display("%0t: height mismatch, expected %h, actual %h",
					$realtime, heights_due[0], m_axis_tdata);
				void'(heights_due.pop_front());
			end else begin
				void'(heights_due.pop_front());
			end
		end
		m_axis_tready <= draining || ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= 5000) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		logic [31:0] cfg [6][6];
		int          modes [6][2];
		int          w, h, base;
		clk           = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		m_axis_tready = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_addr      = '0;
		cfg_wdata     = '0;
		draining      = 1'b0;
		quiet         = 0;
		errors        = 0;
		results       = 0;
		n_queries     = 0;
		n_writes      = 0;
		idle_pct      = 0;
		stall_pct     = 0;
		org_x         = 0;
		org_z         = 0;
		uv_scale      = 0;
		h_scale       = 32'd65536;
		side_w        = 9'd256;
		side_h        = 9'd256;
		cfg = '{
			'{32'd0, 32'd0, $urandom, 32'd65536, 32'd4, 32'd4},
			'{32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd0, 32'd511},
			'{$urandom, $urandom, $urandom, $urandom, 32'd256, 32'd256},
			'{$urandom, 32'h80000000, $urandom, 32'd0, 32'd1, 32'd8},
			'{$urandom, $urandom, $urandom, $urandom_range(1 << 20),
				$urandom_range(16, 1), $urandom_range(16, 1)},
			'{32'd0, 32'd0, 32'h00010000, $urandom_range(1 << 18), 32'd256, 32'd1}
		};
		modes = '{'{0, 0}, '{75, 0}, '{0, 75}, '{12, 12}, '{0, 0}, '{75, 75}};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[r]) begin
			if (rows[r].op == hbs_pkg::OP_WRITE)
				push_beat(hbs_pkg::OP_WRITE, rows[r].addr, rows[r].val, rows[r].qx,
					rows[r].qz, 0, 0);
			else
				run_query(rows[r].qx, rows[r].qz, rows[r].typed, rows[r].height);
		end

		for (int p = 0; p < 6; p++) begin
			drain();
			for (int g = 0; g < 6; g++)
				set_reg(3'(g), cfg[p][g]);
			cfg_wr_en <= 1'b0;
			idle_pct  = modes[p][0];
			stall_pct = modes[p][1];
			w = eff_side(side_w);
			h = eff_side(side_h);
			base = n_writes + n_queries;
			for (int n = 0; n_writes + n_queries - base < 72; n++) begin
				if (p == 4 && n == 12)
					drain();
				if ($urandom_range(99) < 35)
					push_beat(hbs_pkg::OP_WRITE, 16'($urandom_range(w * h - 1)),
						16'($urandom), $urandom, $urandom, 0, 0);
				else if ($urandom_range(99) < 70)
					run_query(near_origin(org_x), near_origin(org_z), 0, 0);
				else
					run_query($urandom, $urandom, 0, 0);
			end
		end

		drain();
		$display("%0d writes and %0d queries over 6 register settings, %0d heights checked",
			n_writes, n_queries, results);
		$display("idling: none, sender, receiver and both; extremes of origin, scale and size");
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
design/hbs_pkg.sv
design/heightmap_bilinear_sampler.sv
tb/heightmap_bilinear_sampler_tb.sv
